// ===== hdl/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } rsp_type;

   // block job handed from front to back
   typedef struct packed {
      logic [511:0] block;
      logic         last;
   } job_type;

   localparam int QueueDepth = 2;

   localparam logic [255:0] InitHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PadByte = 8'h80;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sha_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sha_pkg::req_type req_data,
   output logic                  job_valid,
   output sha_pkg::job_type      job_data,
   input  wire logic             job_ready
);
   import sha_pkg::*;

   typedef enum logic [1:0] {ST_FILL, ST_PAD, ST_LEN} state_type;

   state_type    state_ff;
   logic [511:0] block_ff;
   logic [5:0]   fill_ff;
   logic [60:0]  total_ff;
   logic         valid_ff;
   logic         last_ff;
   logic         take;
   logic [63:0]  bits;
   logic [511:0] pad_block;

   assign req_full  = (state_ff != ST_FILL) || valid_ff;
   assign take      = req_push && !req_full;
   assign job_valid = valid_ff;
   assign job_data  = '{block: block_ff, last: last_ff};
   assign bits      = {total_ff, 3'b000};

   // pad marker after the held bytes, zeros behind it
   always_comb begin
      pad_block = block_ff;
      for (int i = 0; i < 64; i++) begin
         if (i == int'(fill_ff)) pad_block[511 - 8*i -: 8] = PadByte;
         else if (i > int'(fill_ff)) pad_block[511 - 8*i -: 8] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff  <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         if (valid_ff && job_ready) valid_ff <= 1'b0;
         case (state_ff)
            ST_FILL: begin
               if (take) begin
                  if (req_data.byte_valid) begin
                     block_ff[511 - 8*fill_ff -: 8] <= req_data.msg_byte;
                     fill_ff  <= fill_ff + 6'd1;
                     total_ff <= total_ff + 61'd1;
                     if (fill_ff == 6'd63) begin
                        valid_ff <= 1'b1;
                        last_ff  <= 1'b0;
                     end
                  end
                  if (req_data.end_of_message) state_ff <= ST_PAD;
               end
            end
            ST_PAD: begin
               if (!valid_ff) begin
                  if (fill_ff >= 6'd56) begin
                     block_ff <= pad_block;
                     valid_ff <= 1'b1;
                     last_ff  <= 1'b0;
                     fill_ff  <= '0;
                     state_ff <= ST_LEN;
                  end else begin
                     block_ff <= {pad_block[511:64], bits};
                     valid_ff <= 1'b1;
                     last_ff  <= 1'b1;
                     fill_ff  <= '0;
                     total_ff <= '0;
                     state_ff <= ST_FILL;
                  end
               end
            end
            ST_LEN: begin
               if (!valid_ff) begin
                  block_ff <= {448'b0, bits};
                  valid_ff <= 1'b1;
                  last_ff  <= 1'b1;
                  total_ff <= '0;
                  state_ff <= ST_FILL;
               end
            end
            default: state_ff <= ST_FILL;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !job_ready |=> valid_ff)
      else $error("job dropped");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) && last_ff |-> total_ff == '0)
      else $error("length not cleared");
   a_pad_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEN |-> fill_ff == '0)
      else $error("bad fill in length state");
`endif
endmodule
`default_nettype wire

// ===== hdl/sha_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire sha_pkg::job_type job_data,
   output logic                  job_ready,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output sha_pkg::rsp_type      rsp_data
);
   import sha_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ADD, ST_OUT} state_type;

   localparam int QIdx = $clog2(QueueDepth);

   job_type      q_ff [QueueDepth];
   logic [QIdx:0] cnt_ff;
   logic [QIdx-1:0] wp_ff, rp_ff;
   state_type    state_ff;
   logic [5:0]   round_ff;
   logic [31:0]  w_ff [16];
   logic [31:0]  v_ff [8];
   logic [31:0]  h_ff [8];
   logic         last_ff;
   logic [2:0]   idx_ff;
   logic         push, pop;
   logic [31:0]  wt, wn, t1, t2, s0, s1;

   assign job_ready = cnt_ff != (QIdx+1)'(QueueDepth);
   assign push = job_valid && job_ready;
   assign pop  = state_ff == ST_IDLE && cnt_ff != '0;
   assign rsp_empty = state_ff != ST_OUT;
   assign rsp_data = '{digest_word: h_ff[idx_ff], word_index: idx_ff,
                       final_word: idx_ff == 3'd7};

   always_comb begin
      wt = w_ff[0];
      wn = w_ff[0] + (ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3))
         + w_ff[9] + (ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10));
      s1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      t1 = v_ff[7] + s1 + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + round_k(round_ff) + wt;
      s0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      t2 = s0 + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= job_data;
      if (reset) begin
         cnt_ff   <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[255 - 32*i -: 32];
      end else begin
         if (push) wp_ff <= wp_ff + QIdx'(1);
         if (pop) rp_ff <= rp_ff + QIdx'(1);
         cnt_ff <= cnt_ff + (QIdx+1)'(push) - (QIdx+1)'(pop);
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  for (int i = 0; i < 16; i++)
                     w_ff[i] <= q_ff[rp_ff].block[511 - 32*i -: 32];
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  last_ff  <= q_ff[rp_ff].last;
                  round_ff <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wn;
               for (int i = 1; i < 8; i++)
                  if (i != 4) v_ff[i] <= v_ff[i-1];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               idx_ff   <= '0;
               state_ff <= last_ff ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
               if (rsp_pop) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++)
                        h_ff[i] <= InitHash[255 - 32*i -: 32];
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QIdx+1)'(QueueDepth))
      else $error("queue overflow");
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(round_ff) == 6'd63)
      else $error("round count");
   a_out_reset: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_pop && idx_ff == 3'd7 |=> state_ff == ST_IDLE)
      else $error("digest end");
`endif
endmodule
`default_nettype wire

// ===== hdl/sha256_stream_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// req       in         req_push / req_full  sha_pkg::req_type (one byte)
// rsp       out        rsp_pop / rsp_empty  sha_pkg::rsp_type (digest word)
//
// one byte per cycle while the front is filling a block and its block buffer is free
// each 64-byte block is loaded in ST_IDLE, runs all rounds in ST_RUN and is added in ST_ADD in the shared round unit
// a message ends with one or two pad blocks, then eight digest transactions
// synchronous reset restores the initial hash and empties the block queue
// the front stalls while a finished block waits; the core stalls on rsp_pop
module sha256_stream_hash (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sha_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output sha_pkg::rsp_type      rsp_data
);
   import sha_pkg::*;

   logic    job_valid;
   logic    job_ready;
   job_type job_data;

   sha_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .job_valid, .job_data, .job_ready);

   sha_core u_core (
      .clock, .reset, .job_valid, .job_data, .job_ready,
      .rsp_pop, .rsp_empty, .rsp_data);
endmodule
`default_nettype wire
